/* hw/rtl/kss_pkg.sv */
package kss_pkg;

	localparam int STORE_ENTRIES = 4096;
	localparam int MAX_BASES = 32;
	localparam int IDX_W = $clog2(STORE_ENTRIES);
	localparam int KEY_W = 64;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_BASE   = 2'd2,
		MODE_END    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_DONE     = 2'd0,
		STATUS_NOT_HELD = 2'd1,
		STATUS_FULL     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK
	} state_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [KEY_W-1:0] kmer_key;
		logic [1:0]       base_code;
		logic             base_valid;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        sequence_hit;
		logic [31:0] record_number;
	} result_t;

	// A slot that was never used ends a probe chain; a used slot with a zero
	// count is free but the chain runs on past it.
	typedef struct packed {
		logic       used;
		logic [7:0] count;
	} meta_t;

	// Write request from the sequencer to the slot memories.
	typedef struct packed {
		logic             meta_we;
		logic             key_we;
		logic [IDX_W-1:0] addr;
		meta_t            meta;
		logic [KEY_W-1:0] key;
	} tbl_wr_t;

	// Home slot of a key: all key bits folded onto the index width by xor.
	function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] key);
		logic [IDX_W-1:0] h;
		h = '0;
		for (int i = 0; i < KEY_W; i++) begin
			h[i % IDX_W] = h[i % IDX_W] ^ key[i];
		end
		return h;
	endfunction

endpackage

/* hw/rtl/kss_table.sv */
module kss_table (
	input  logic                      clk,
	input  kss_pkg::tbl_wr_t          wr,
	input  logic [kss_pkg::IDX_W-1:0] raddr,
	output kss_pkg::meta_t            rd_meta,
	output logic [kss_pkg::KEY_W-1:0] rd_key
);
	import kss_pkg::*;

	meta_t            meta_mem [STORE_ENTRIES];
	logic [KEY_W-1:0] key_mem  [STORE_ENTRIES];

	// Slot metadata: one write and one registered read each cycle.
	always_ff @(posedge clk) begin
		if (wr.meta_we) begin
			meta_mem[wr.addr] <= wr.meta;
		end
		rd_meta <= meta_mem[raddr];
	end

	// Slot keys: same addressing, never cleared.
	always_ff @(posedge clk) begin
		if (wr.key_we) begin
			key_mem[wr.addr] <= wr.key;
		end
		rd_key <= key_mem[raddr];
	end

endmodule

/* hw/rtl/kmer_set_sequence_filter.sv */
// k-mer set filter with a counted hash store.
// A request is taken on a rising edge with start high and busy low. Its
// mode selects insert of a k-mer, remove of a k-mer, one sequence base,
// or end of sequence. Exactly one result follows per request: done is
// high for one cycle with the result fields, and the receiver cannot
// stall it, so it must take the result in that cycle.
// The user must write the window length register with cfg_we and cfg_data
// only while the block is idle; the block does not enforce it. It resets to 16 bases.
// End of sequence, an invalid letter, or a base that does not yet fill the
// window returns its result in the cycle after acceptance. Insert, remove
// and a full-window base probe the store with linear probing from a hashed
// home slot, one slot per cycle; at most 4096 slots are probed. The slot
// memory has a single read port.
// After reset the block clears the metadata of all 4096 slots, one slot per
// cycle, and holds busy high meanwhile. Register writes are taken during
// that time.
module kmer_set_sequence_filter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [5:0]        cfg_data,
	input  logic              start,
	input  kss_pkg::request_t request,
	output logic              busy,
	output logic              done,
	output kss_pkg::result_t  result
);
	import kss_pkg::*;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] clr_q, clr_d;
	logic [1:0]       op_q, op_d;
	logic [KEY_W-1:0] key_q, key_d;
	logic [IDX_W-1:0] addr_q, addr_d;
	logic [IDX_W-1:0] probes_q, probes_d;
	logic             free_found_q, free_found_d;
	logic [IDX_W-1:0] free_idx_q, free_idx_d;
	logic [KEY_W-1:0] window_q, window_d;
	logic [5:0]       run_q, run_d;
	logic             hit_q, hit_d;
	logic [31:0]      rec_q, rec_d;
	logic [5:0]       klen_q;
	logic             done_q, done_d;
	result_t          result_q, result_d;

	tbl_wr_t          wr;
	logic [IDX_W-1:0] raddr;
	meta_t            rd_meta;
	logic [KEY_W-1:0] rd_key;

	logic [5:0]       k_eff;
	logic [KEY_W-1:0] win_mask;
	logic [KEY_W-1:0] win_next;
	logic [5:0]       run_next;
	logic             match;
	logic             chain_end;
	logic             cand_ok;
	logic [IDX_W-1:0] cand_idx;

	kss_table u_table (
		.clk     (clk),
		.wr      (wr),
		.raddr   (raddr),
		.rd_meta (rd_meta),
		.rd_key  (rd_key)
	);

	// Effective window length and the mask of its 2k bits.
	always_comb begin
		k_eff = klen_q;
		if (k_eff == 6'd0) begin
			k_eff = 6'd1;
		end
		if (k_eff > 6'(MAX_BASES)) begin
			k_eff = 6'(MAX_BASES);
		end
		for (int i = 0; i < KEY_W; i++) begin
			win_mask[i] = (i < 2 * int'(k_eff));
		end
		win_next = {window_q[KEY_W-3:0], request.base_code} & win_mask;
		run_next = (run_q < k_eff) ? run_q + 6'd1 : run_q;
	end

	// Probe decision on the slot read in the previous cycle.
	always_comb begin
		match     = (rd_meta.count != 8'd0) && (rd_key == key_q);
		chain_end = !rd_meta.used || (probes_q == IDX_W'(STORE_ENTRIES - 1));
		if (free_found_q) begin
			cand_ok  = 1'b1;
			cand_idx = free_idx_q;
		end else begin
			cand_ok  = (rd_meta.count == 8'd0);
			cand_idx = addr_q;
		end
	end

	// Sequencer: next state, memory requests and result.
	always_comb begin
		state_d      = state_q;
		clr_d        = clr_q;
		op_d         = op_q;
		key_d        = key_q;
		addr_d       = addr_q;
		probes_d     = probes_q;
		free_found_d = free_found_q;
		free_idx_d   = free_idx_q;
		window_d     = window_q;
		run_d        = run_q;
		hit_d        = hit_q;
		rec_d        = rec_q;
		done_d       = 1'b0;
		result_d     = '0;
		raddr        = addr_q;
		wr           = '0;
		wr.addr      = addr_q;
		wr.key       = key_q;

		case (state_q)
			ST_CLEAR: begin
				wr.meta_we = 1'b1;
				wr.addr    = clr_q;
				wr.meta    = '0;
				clr_d      = clr_q + 1'b1;
				if (clr_q == IDX_W'(STORE_ENTRIES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					op_d         = request.mode;
					probes_d     = '0;
					free_found_d = 1'b0;
					case (request.mode)
						MODE_INSERT, MODE_REMOVE: begin
							key_d   = request.kmer_key;
							addr_d  = home_slot(request.kmer_key);
							state_d = ST_READ;
						end
						MODE_BASE: begin
							if (!request.base_valid) begin
								window_d = '0;
								run_d    = '0;
								done_d   = 1'b1;
							end else begin
								window_d = win_next;
								run_d    = run_next;
								if (run_next >= k_eff) begin
									key_d   = win_next;
									addr_d  = home_slot(win_next);
									state_d = ST_READ;
								end else begin
									done_d = 1'b1;
								end
							end
						end
						default: begin
							if (hit_q) begin
								result_d.sequence_hit  = 1'b1;
								result_d.record_number = rec_q;
								rec_d = (rec_q == 32'hFFFF_FFFF) ? 32'd1 : rec_q + 32'd1;
							end
							window_d = '0;
							run_d    = '0;
							hit_d    = 1'b0;
							done_d   = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (match) begin
					// Key held: update its count or flag the window hit.
					wr.meta.used = 1'b1;
					case (op_q)
						MODE_INSERT: begin
							wr.meta_we    = 1'b1;
							wr.meta.count = (rd_meta.count == 8'hFF) ? 8'hFF
								: rd_meta.count + 8'd1;
						end
						MODE_REMOVE: begin
							wr.meta_we    = 1'b1;
							wr.meta.count = rd_meta.count - 8'd1;
						end
						default: begin
							hit_d = 1'b1;
						end
					endcase
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else if (chain_end) begin
					// Key not held: insert takes the first free slot seen.
					case (op_q)
						MODE_INSERT: begin
							if (cand_ok) begin
								wr.meta_we = 1'b1;
								wr.key_we  = 1'b1;
								wr.addr    = cand_idx;
								wr.meta    = '{used: 1'b1, count: 8'd1};
							end else begin
								result_d.status = STATUS_FULL;
							end
						end
						MODE_REMOVE: begin
							result_d.status = STATUS_NOT_HELD;
						end
						default: begin
						end
					endcase
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					// Used slot, key not held there: remember a free one and probe on.
					if (!free_found_q && rd_meta.count == 8'd0) begin
						free_found_d = 1'b1;
						free_idx_d   = addr_q;
					end
					raddr    = addr_q + 1'b1;
					addr_d   = addr_q + 1'b1;
					probes_d = probes_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			window_q <= '0;
			run_q    <= '0;
			hit_q    <= 1'b0;
			rec_q    <= 32'd1;
			klen_q   <= 6'd16;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			clr_q    <= clr_d;
			window_q <= window_d;
			run_q    <= run_d;
			hit_q    <= hit_d;
			rec_q    <= rec_d;
			done_q   <= done_d;
			if (cfg_we) begin
				klen_q <= cfg_data;
			end
		end
	end

	// Request and probe payload registers.
	always_ff @(posedge clk) begin
		op_q         <= op_d;
		key_q        <= key_d;
		addr_q       <= addr_d;
		probes_q     <= probes_d;
		free_found_q <= free_found_d;
		free_idx_q   <= free_idx_d;
		result_q     <= result_d;
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
